// ===== rtl/asof_pkg.sv =====
// Package for the adaptive sample outlier filter.
// Holds the request and result structs, configuration types, register indexes and FSM states.
// No dependencies.
`default_nettype none

package asof_pkg;

    localparam int SAMPLE_W = 16;

    typedef struct packed {
        logic [7:0] sample_high;
        logic [7:0] sample_low;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered_value;
        logic                accepted;
    } t_out;

    typedef struct packed {
        logic                thermometer_mode;
        logic [SAMPLE_W-1:0] band_low;
        logic [SAMPLE_W-1:0] band_high;
        logic [SAMPLE_W-1:0] floor_value;
    } t_cfg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THERMOMETER_MODE = 2'd0,
        REG_BAND_LOW         = 2'd1,
        REG_BAND_HIGH        = 2'd2,
        REG_FLOOR_VALUE      = 2'd3
    } t_reg_idx;

    localparam logic [SAMPLE_W-1:0] RST_BAND_LOW    = 16'd3000;
    localparam logic [SAMPLE_W-1:0] RST_BAND_HIGH   = 16'd4000;
    localparam logic [SAMPLE_W-1:0] RST_FLOOR_VALUE = 16'd60;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THERM,
        ST_WALK,
        ST_TAIL,
        ST_MUL,
        ST_DEC
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/asof_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependencies.
`default_nettype none

module asof_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/asof_cfg.sv =====
// Configuration register file of the adaptive sample outlier filter.
// Depends on asof_pkg for the register indexes, reset values and the t_cfg struct.
`default_nettype none

module asof_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [asof_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [asof_pkg::SAMPLE_W-1:0]    i_data,
    output asof_pkg::t_cfg                        o_cfg
);

    asof_pkg::t_cfg r_cfg;
    asof_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (asof_pkg::t_reg_idx'(i_index))
                asof_pkg::REG_THERMOMETER_MODE: n_cfg.thermometer_mode = i_data[0];
                asof_pkg::REG_BAND_LOW:         n_cfg.band_low         = i_data;
                asof_pkg::REG_BAND_HIGH:        n_cfg.band_high        = i_data;
                asof_pkg::REG_FLOOR_VALUE:      n_cfg.floor_value      = i_data;
                default:                        n_cfg                  = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thermometer_mode <= 1'b0;
            r_cfg.band_low         <= asof_pkg::RST_BAND_LOW;
            r_cfg.band_high        <= asof_pkg::RST_BAND_HIGH;
            r_cfg.floor_value      <= asof_pkg::RST_FLOOR_VALUE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/adaptive_sample_outlier_filter.sv =====
// Top level of the adaptive sample outlier filter: control FSM, history walk and decision.
// Depends on asof_pkg, asof_cfg and asof_ram.
//
// Usage. Sample requests arrive on i_in_valid / o_in_stall with the 16-bit sample split
// into a high and a low byte; filtered results leave on o_out_valid / i_out_stall. A
// request moves when valid is high and stall is low. Configuration writes use
// i_cfg_valid / o_cfg_ready with a register index and data; they should only be issued
// while the filter is idle. o_cfg_ready is always high.
// Thermometer mode compares each sample against the configured band and gives no result
// for a sample at or below the floor. Adaptive mode writes every sample into a history
// RAM; once warm-up is over, the filter walks WINDOW+1 earlier entries through the RAM's
// single read port, one per cycle, and accumulates absolute differences. An item then
// passes through accept, WINDOW+1 reads, read drain, one multiply and the decision.
// During warm-up an adaptive item gives no result. The filter works on one request at a
// time; o_in_stall is high while an item is in progress. Results sit in an output
// register, so a stalled receiver only holds the block at the point where a new result
// must be written into a still-full register. Reset is synchronous and active low: it
// restores the configuration defaults and marks all history entries as empty, which
// reads as zero, without a clearing pass.
`default_nettype none

module adaptive_sample_outlier_filter #(
    parameter int WINDOW        = 10,
    parameter int HISTORY_DEPTH = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire asof_pkg::t_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output asof_pkg::t_out                      o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [asof_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [asof_pkg::SAMPLE_W-1:0]  i_cfg_data
);

    localparam int SW     = asof_pkg::SAMPLE_W;
    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SW + $clog2(WINDOW);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [SUM_W-1:0] DIVISOR  = SUM_W'(WINDOW - 1);

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
        ring_prev = (idx == '0) ? LAST_IDX : idx - PTR_W'(1);
    endfunction

    function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        abs_diff = (a >= b) ? a - b : b - a;
    endfunction

    // Configuration registers.
    asof_pkg::t_cfg cfg;

    assign o_cfg_ready = 1'b1;

    asof_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Control and datapath registers.
    asof_pkg::t_state   r_state, n_state;
    logic [PTR_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_seen, n_seen;
    logic               r_active, n_active;
    logic [SW-1:0]      r_last_acc, n_last_acc;
    logic [HISTORY_DEPTH-1:0] r_valid, n_valid;
    logic [SW-1:0]      r_sample, n_sample;
    logic [PTR_W-1:0]   r_addr, n_addr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_dv;
    logic [CNT_W-1:0]   r_didx;
    logic               r_dok;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [SW-1:0]      r_prev, n_prev;
    logic [SW-1:0]      r_tail, n_tail;
    logic [SUM_W-1:0]   r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    asof_pkg::t_out     r_out, n_out;

    logic               ram_we;
    logic [SW-1:0]      ram_rdata;
    logic [SW-1:0]      rd_val;
    logic [SW-1:0]      in_sample;
    logic               in_acc;
    logic               out_free;
    logic               pass;

    assign in_sample = {i_in_data.sample_high, i_in_data.sample_low};
    assign o_in_stall = (r_state != asof_pkg::ST_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Entries never written since reset read as zero.
    assign rd_val = r_dok ? ram_rdata : '0;

    // |s - prev| <= floor(sum / (WINDOW-1)) is the same as |s - prev| * (WINDOW-1) <= sum.
    assign pass = (r_prod <= r_sum) && (r_sample > cfg.floor_value);

    asof_ram #(
        .WIDTH (SW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (in_sample),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_seen      = r_seen;
        n_active    = r_active;
        n_last_acc  = r_last_acc;
        n_valid     = r_valid;
        n_sample    = r_sample;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_prev      = r_prev;
        n_tail      = r_tail;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;

        // Read data from the history walk: the first entry is the previous sample,
        // each later one closes a pair with the entry read before it.
        if (r_dv) begin
            n_tail = rd_val;
            if (r_didx == '0) begin
                n_prev = rd_val;
            end else begin
                n_sum = r_sum + SUM_W'(abs_diff(r_tail, rd_val));
            end
        end

        unique case (r_state)
            asof_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_sample = in_sample;
                    if (cfg.thermometer_mode) begin
                        n_state = asof_pkg::ST_THERM;
                    end else begin
                        ram_we         = 1'b1;
                        n_valid[r_ptr] = 1'b1;
                        n_ptr          = (r_ptr == LAST_IDX) ? '0 : r_ptr + PTR_W'(1);
                        if (r_seen < WIN_CNT) begin
                            n_seen = r_seen + CNT_W'(1);
                        end else begin
                            n_active = 1'b1;
                        end
                        if (r_active) begin
                            n_addr  = ring_prev(r_ptr);
                            n_cnt   = '0;
                            n_sum   = '0;
                            n_state = asof_pkg::ST_WALK;
                        end
                    end
                end
            end
            asof_pkg::ST_THERM: begin
                if (r_sample <= cfg.floor_value) begin
                    n_state = asof_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sample > cfg.band_low && r_sample < cfg.band_high) begin
                        n_last_acc = r_sample;
                        n_out      = '{filtered_value: r_sample, accepted: 1'b1};
                    end else begin
                        n_out      = '{filtered_value: r_last_acc, accepted: 1'b0};
                    end
                    if (r_seen < WIN_CNT) begin
                        n_seen = r_seen + CNT_W'(1);
                    end else begin
                        n_active = 1'b1;
                    end
                    n_state = asof_pkg::ST_IDLE;
                end
            end
            asof_pkg::ST_WALK: begin
                n_addr = ring_prev(r_addr);
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == WIN_CNT) begin
                    n_state = asof_pkg::ST_TAIL;
                end
            end
            asof_pkg::ST_TAIL: begin
                n_state = asof_pkg::ST_MUL;
            end
            asof_pkg::ST_MUL: begin
                n_prod  = SUM_W'(abs_diff(r_sample, r_prev)) * DIVISOR;
                n_state = asof_pkg::ST_DEC;
            end
            asof_pkg::ST_DEC: begin
                if (pass) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_last_acc  = r_sample;
                        n_out       = '{filtered_value: r_sample, accepted: 1'b1};
                        n_state     = asof_pkg::ST_IDLE;
                    end
                end else if (r_sample != '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{filtered_value: r_last_acc, accepted: 1'b0};
                        n_state     = asof_pkg::ST_IDLE;
                    end
                end else begin
                    n_state = asof_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = asof_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asof_pkg::ST_IDLE;
            r_ptr       <= '0;
            r_seen      <= '0;
            r_active    <= 1'b0;
            r_last_acc  <= '0;
            r_valid     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_seen      <= n_seen;
            r_active    <= n_active;
            r_last_acc  <= n_last_acc;
            r_valid     <= n_valid;
            r_dv        <= (r_state == asof_pkg::ST_WALK);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_didx   <= r_cnt;
        r_dok    <= r_valid[r_addr];
        r_sum    <= n_sum;
        r_prev   <= n_prev;
        r_tail   <= n_tail;
        r_prod   <= n_prod;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
